// ===== design/color_blend_unit_top_assert.svh =====
// Assertion macros used by the color blend unit RTL.
// Included by color_blend_unit_top, which checks its own logic; no other dependencies.
`ifndef COLOR_BLEND_UNIT_TOP_ASSERT_SVH
`define COLOR_BLEND_UNIT_TOP_ASSERT_SVH

`ifndef SYNTH
`define CBU_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("cbu assertion failed");
`define CBU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbu assertion failed");
`else
`define CBU_ASSERT(name, clk, rst, prop)
`define CBU_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== design/cbu_pkg.sv =====
// Types and constants of the color blend unit.
// Used by cbu_channel and color_blend_unit_top; no dependencies.
package cbu_pkg;

   localparam int FIELD_BITS = 8;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [3:0][FIELD_BITS-1:0] rgba_type;

   localparam logic [1:0] CH_RED = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE = 2'd2;
   localparam logic [1:0] CH_ALPHA = 2'd3;

   typedef enum logic [3:0] {
      FACTOR_ZERO            = 4'd0,
      FACTOR_ONE             = 4'd1,
      FACTOR_SRC_COLOR       = 4'd2,
      FACTOR_INV_SRC_COLOR   = 4'd3,
      FACTOR_DST_COLOR       = 4'd4,
      FACTOR_INV_DST_COLOR   = 4'd5,
      FACTOR_SRC_ALPHA       = 4'd6,
      FACTOR_INV_SRC_ALPHA   = 4'd7,
      FACTOR_DST_ALPHA       = 4'd8,
      FACTOR_INV_DST_ALPHA   = 4'd9,
      FACTOR_CONST_COLOR     = 4'd10,
      FACTOR_INV_CONST_COLOR = 4'd11,
      FACTOR_CONST_ALPHA     = 4'd12,
      FACTOR_INV_CONST_ALPHA = 4'd13,
      FACTOR_ALPHA_SATURATE  = 4'd14
   } factor_type;

   typedef enum logic [2:0] {
      EQ_ADD     = 3'd0,
      EQ_SUB     = 3'd1,
      EQ_REV_SUB = 3'd2,
      EQ_MIN     = 3'd3,
      EQ_MAX     = 3'd4
   } equation_type;

   typedef struct packed {
      factor_type   src_factor;
      factor_type   dst_factor;
      equation_type equation;
   } chan_cfg_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLEND_ENABLE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RGB_SRC_FACTOR  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RGB_DST_FACTOR  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_SRC_FACTOR = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_DST_FACTOR = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RGB_EQUATION    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_EQUATION  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONSTANT_RGBA   = 3'd7;

endpackage

// ===== design/cbu_channel.sv =====
// Blend datapath for one color channel: factor select, scale and combine.
// Depends on cbu_pkg.
module cbu_channel #(
   parameter int CHANNEL_BITS = 8,
   parameter bit ALPHA_USE = 1'b0
) (
   input  logic [CHANNEL_BITS-1:0] src_val,
   input  logic [CHANNEL_BITS-1:0] dst_val,
   input  logic [CHANNEL_BITS-1:0] src_alpha,
   input  logic [CHANNEL_BITS-1:0] dst_alpha,
   input  logic [CHANNEL_BITS-1:0] const_val,
   input  logic [CHANNEL_BITS-1:0] const_alpha,
   input  cbu_pkg::chan_cfg_type   cfg,
   output logic [CHANNEL_BITS-1:0] result
);
   import cbu_pkg::*;

   localparam int CB = CHANNEL_BITS;
   localparam logic [CB-1:0] CH_MAX = {CB{1'b1}};
   localparam logic [2*CB:0] HALF = (2*CB+1)'(1) << (CB-1);

   function automatic logic [CB-1:0] factor_of(factor_type code);
      logic [CB-1:0] sat;
      sat = CH_MAX - dst_alpha;
      case (code)
         FACTOR_ONE:             return CH_MAX;
         FACTOR_SRC_COLOR:       return src_val;
         FACTOR_INV_SRC_COLOR:   return CH_MAX - src_val;
         FACTOR_DST_COLOR:       return dst_val;
         FACTOR_INV_DST_COLOR:   return CH_MAX - dst_val;
         FACTOR_SRC_ALPHA:       return src_alpha;
         FACTOR_INV_SRC_ALPHA:   return CH_MAX - src_alpha;
         FACTOR_DST_ALPHA:       return dst_alpha;
         FACTOR_INV_DST_ALPHA:   return CH_MAX - dst_alpha;
         FACTOR_CONST_COLOR:     return const_val;
         FACTOR_INV_CONST_COLOR: return CH_MAX - const_val;
         FACTOR_CONST_ALPHA:     return const_alpha;
         FACTOR_INV_CONST_ALPHA: return CH_MAX - const_alpha;
         FACTOR_ALPHA_SATURATE: begin
            if (ALPHA_USE) begin
               return CH_MAX;
            end else begin
               return (src_alpha < sat) ? src_alpha : sat;
            end
         end
         default:                return '0;
      endcase
   endfunction

   // Rounded a*f/M with M = 2^CB-1, done by the add-and-shift identity.
   function automatic logic [CB-1:0] scale(logic [CB-1:0] a, logic [CB-1:0] f);
      logic [2*CB-1:0] prod;
      logic [2*CB:0]   q;
      logic [2*CB:0]   r;
      prod = {{CB{1'b0}}, a} * {{CB{1'b0}}, f};
      q = {1'b0, prod} + HALF;
      r = (q + (q >> CB)) >> CB;
      return r[CB-1:0];
   endfunction

   logic [CB-1:0] src_scaled;
   logic [CB-1:0] dst_scaled;
   logic [CB:0]   sum;

   always_comb begin
      src_scaled = scale(src_val, factor_of(cfg.src_factor));
      dst_scaled = scale(dst_val, factor_of(cfg.dst_factor));
      sum = {1'b0, src_scaled} + {1'b0, dst_scaled};
      case (cfg.equation)
         EQ_SUB: begin
            result = (src_scaled > dst_scaled) ? src_scaled - dst_scaled : '0;
         end
         EQ_REV_SUB: begin
            result = (dst_scaled > src_scaled) ? dst_scaled - src_scaled : '0;
         end
         EQ_MIN: begin
            result = (src_scaled < dst_scaled) ? src_scaled : dst_scaled;
         end
         EQ_MAX: begin
            result = (src_scaled > dst_scaled) ? src_scaled : dst_scaled;
         end
         default: begin
            result = sum[CB] ? CH_MAX : sum[CB-1:0];
         end
      endcase
   end

endmodule

// ===== design/color_blend_unit_top.sv =====
// Top level of the color blend unit: register file, input and result stages.
// Depends on cbu_pkg, cbu_channel and color_blend_unit_top_assert.svh.
//
// The req channel carries one fragment per transaction: source and framebuffer
// RGBA. The rsp channel returns the blended RGBA, one transaction per request,
// in order. Both use valid/ready handshakes.
// A request is captured in an input register, blended by one pass of
// combinational logic (factor select, one multiply per term, rounding and
// combine) and stored in the result register. rsp_valid rises when the request
// moves on from the input register, which waits while a stalled result holds.
// Throughput is one transaction per cycle while rsp_ready stays high; the
// multiply and rounding path of each channel sets the cycle time.
// When the receiver stalls, the result register holds and the input register
// fills; req_ready drops only when both stages are occupied and rsp_ready is low.
// The csr port writes one blend register per cycle with csr_we high; write it
// only while no transaction is in flight.
// Reset empties both stages and restores the defaults: blending off, source
// factor one, destination factor zero, add, constant color zero.
`include "color_blend_unit_top_assert.svh"

module color_blend_unit_top #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cbu_pkg::FIELD_BITS-1:0]      req_src_red,
   input  logic [cbu_pkg::FIELD_BITS-1:0]      req_src_green,
   input  logic [cbu_pkg::FIELD_BITS-1:0]      req_src_blue,
   input  logic [cbu_pkg::FIELD_BITS-1:0]      req_src_alpha,
   input  logic [cbu_pkg::FIELD_BITS-1:0]      req_dst_red,
   input  logic [cbu_pkg::FIELD_BITS-1:0]      req_dst_green,
   input  logic [cbu_pkg::FIELD_BITS-1:0]      req_dst_blue,
   input  logic [cbu_pkg::FIELD_BITS-1:0]      req_dst_alpha,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cbu_pkg::FIELD_BITS-1:0]      rsp_out_red,
   output logic [cbu_pkg::FIELD_BITS-1:0]      rsp_out_green,
   output logic [cbu_pkg::FIELD_BITS-1:0]      rsp_out_blue,
   output logic [cbu_pkg::FIELD_BITS-1:0]      rsp_out_alpha,
   input  logic                                csr_we,
   input  logic [cbu_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cbu_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import cbu_pkg::*;

   localparam int CB = CHANNEL_BITS;

   localparam chan_cfg_type CFG_RESET = '{
      src_factor: FACTOR_ONE,
      dst_factor: FACTOR_ZERO,
      equation:   EQ_ADD
   };

   logic         blend_enable_ff, blend_enable_in;
   chan_cfg_type rgb_cfg_ff, rgb_cfg_in;
   chan_cfg_type alpha_cfg_ff, alpha_cfg_in;
   rgba_type     const_ff, const_in;

   logic         s1_valid_ff, s1_valid_in;
   rgba_type     src_ff, src_in;
   rgba_type     dst_ff, dst_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rgba_type     rsp_data_ff, rsp_data_in;

   logic         s1_advance;
   rgba_type     pass_data;
   rgba_type     blend_data;

   logic [FIELD_BITS+CB-1:0] src_wide [4];
   logic [FIELD_BITS+CB-1:0] dst_wide [4];
   logic [FIELD_BITS+CB-1:0] const_wide [4];
   logic [CB-1:0]            src_ch [4];
   logic [CB-1:0]            dst_ch [4];
   logic [CB-1:0]            const_ch [4];
   logic [CB-1:0]            blend_ch [4];
   logic [FIELD_BITS+CB-1:0] src_out_wide [4];
   logic [FIELD_BITS+CB-1:0] blend_out_wide [4];

   always_comb begin
      blend_enable_in = blend_enable_ff;
      rgb_cfg_in = rgb_cfg_ff;
      alpha_cfg_in = alpha_cfg_ff;
      const_in = const_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BLEND_ENABLE:     blend_enable_in = csr_wdata[0];
            CSR_RGB_SRC_FACTOR:   rgb_cfg_in.src_factor = factor_type'(csr_wdata[3:0]);
            CSR_RGB_DST_FACTOR:   rgb_cfg_in.dst_factor = factor_type'(csr_wdata[3:0]);
            CSR_ALPHA_SRC_FACTOR: alpha_cfg_in.src_factor = factor_type'(csr_wdata[3:0]);
            CSR_ALPHA_DST_FACTOR: alpha_cfg_in.dst_factor = factor_type'(csr_wdata[3:0]);
            CSR_RGB_EQUATION:     rgb_cfg_in.equation = equation_type'(csr_wdata[2:0]);
            CSR_ALPHA_EQUATION:   alpha_cfg_in.equation = equation_type'(csr_wdata[2:0]);
            CSR_CONSTANT_RGBA:    const_in = rgba_type'(csr_wdata);
            default:              blend_enable_in = blend_enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_enable_ff <= 1'b0;
         rgb_cfg_ff <= CFG_RESET;
         alpha_cfg_ff <= CFG_RESET;
         const_ff <= '0;
      end else begin
         blend_enable_ff <= blend_enable_in;
         rgb_cfg_ff <= rgb_cfg_in;
         alpha_cfg_ff <= alpha_cfg_in;
         const_ff <= const_in;
      end
   end

   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in = req_ready ? req_valid : s1_valid_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      if (req_valid && req_ready) begin
         src_in = {req_src_alpha, req_src_blue, req_src_green, req_src_red};
         dst_in = {req_dst_alpha, req_dst_blue, req_dst_green, req_dst_red};
      end
      rsp_valid_in = s1_advance ? s1_valid_ff : rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (s1_valid_ff && s1_advance) begin
         rsp_data_in = blend_enable_ff ? blend_data : pass_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      dst_ff <= dst_in;
      rsp_data_ff <= rsp_data_in;
   end

   for (genvar k = 0; k < 4; k++) begin : g_chan
      assign src_wide[k] = {{CB{1'b0}}, src_ff[k]};
      assign dst_wide[k] = {{CB{1'b0}}, dst_ff[k]};
      assign const_wide[k] = {{CB{1'b0}}, const_ff[k]};
      assign src_ch[k] = src_wide[k][CB-1:0];
      assign dst_ch[k] = dst_wide[k][CB-1:0];
      assign const_ch[k] = const_wide[k][CB-1:0];

      cbu_channel #(
         .CHANNEL_BITS (CB),
         .ALPHA_USE    (k == 3)
      ) u_channel (
         .src_val     (src_ch[k]),
         .dst_val     (dst_ch[k]),
         .src_alpha   (src_ch[CH_ALPHA]),
         .dst_alpha   (dst_ch[CH_ALPHA]),
         .const_val   (const_ch[k]),
         .const_alpha (const_ch[CH_ALPHA]),
         .cfg         ((k == 3) ? alpha_cfg_ff : rgb_cfg_ff),
         .result      (blend_ch[k])
      );

      assign src_out_wide[k] = {{FIELD_BITS{1'b0}}, src_ch[k]};
      assign blend_out_wide[k] = {{FIELD_BITS{1'b0}}, blend_ch[k]};
      assign pass_data[k] = src_out_wide[k][FIELD_BITS-1:0];
      assign blend_data[k] = blend_out_wide[k][FIELD_BITS-1:0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_red = rsp_data_ff[CH_RED];
   assign rsp_out_green = rsp_data_ff[CH_GREEN];
   assign rsp_out_blue = rsp_data_ff[CH_BLUE];
   assign rsp_out_alpha = rsp_data_ff[CH_ALPHA];

   `CBU_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_valid && req_ready, s1_valid_ff)
   `CBU_ASSERT_NEXT(a_s1_moves_to_rsp, clock, reset, s1_valid_ff && s1_advance, rsp_valid_ff)
   `CBU_ASSERT(a_stall_only_when_full, clock, reset,
      req_ready || (s1_valid_ff && rsp_valid_ff && !rsp_ready))
   `CBU_ASSERT_NEXT(a_identity_blend, clock, reset,
      s1_valid_ff && s1_advance && blend_enable_ff &&
      rgb_cfg_ff.src_factor == FACTOR_ONE && rgb_cfg_ff.dst_factor == FACTOR_ZERO &&
      rgb_cfg_ff.equation == EQ_ADD,
      rsp_data_ff[CH_RED] == $past(pass_data[CH_RED]))

endmodule
